/* design/r2fft_pkg.sv */
// r2fft_pkg: sizes, state codes and the Q1.15 quarter-wave sine table
// for the radix-2 FFT core. No dependencies.
package r2fft_pkg;

  localparam int unsigned MaxLog    = 10;
  localparam int unsigned MaxPoints = 1 << MaxLog;
  localparam int unsigned Quarter   = MaxPoints / 4;
  localparam int unsigned SampBits  = 16;
  localparam int unsigned BinBits   = 28;
  localparam int unsigned IdxBits   = MaxLog;
  localparam int unsigned LogBits   = 4;
  localparam int unsigned InBits    = 2 * SampBits;
  localparam int unsigned OutRaw    = 2 * BinBits + IdxBits;
  localparam int unsigned OutBits   = ((OutRaw + 7) / 8) * 8;
  localparam logic [63:0] PiQ31     = 64'h0000_0001_921F_B544;

  // Q40 reciprocals of the Taylor divisors (2n)(2n+1), n = 1..12
  localparam logic [63:0] TaylorRecip [12] = '{
    (64'd1 << 40) / 64'd6,   (64'd1 << 40) / 64'd20,  (64'd1 << 40) / 64'd42,
    (64'd1 << 40) / 64'd72,  (64'd1 << 40) / 64'd110, (64'd1 << 40) / 64'd156,
    (64'd1 << 40) / 64'd210, (64'd1 << 40) / 64'd272, (64'd1 << 40) / 64'd342,
    (64'd1 << 40) / 64'd420, (64'd1 << 40) / 64'd506, (64'd1 << 40) / 64'd600
  };

  localparam logic [0:0] CfgLog2Size = 1'b0;
  localparam logic [0:0] CfgInverse  = 1'b1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_OUTW = 4'd1;
  localparam logic [3:0] ST_CPY  = 4'd2;
  localparam logic [3:0] ST_BRD  = 4'd3;
  localparam logic [3:0] ST_BMR  = 4'd4;
  localparam logic [3:0] ST_BMI  = 4'd5;
  localparam logic [3:0] ST_BWA  = 4'd6;
  localparam logic [3:0] ST_BWB  = 4'd7;
  localparam logic [3:0] ST_SCL  = 4'd8;

  typedef logic [15:0] sine_tab_t [Quarter+1];

  // Evaluated once at elaboration: Q31 Taylor series rounded to Q1.15.
  // Each term is floored by a reciprocal estimate plus one correction step.
  function automatic sine_tab_t build_sine();
    sine_tab_t    tab;
    logic [63:0]  x, term, sum, r, dv, q;
    logic [127:0] prod;
    for (int k = 0; k <= Quarter; k++) begin
      x    = (64'(k) * 64'd2 * PiQ31) >> MaxLog;
      term = x;
      sum  = x;
      for (int n = 1; n <= 12; n++) begin
        dv   = 64'((2 * n) * (2 * n + 1));
        term = (((term * x) >> 31) * x) >> 31;
        prod = 128'(term) * 128'(TaylorRecip[n-1]);
        q    = prod[103:40];
        if ((q + 64'd1) * dv <= term) q = q + 64'd1;
        term = q;
        if ((n & 1) == 1) sum = sum - term;
        else sum = sum + term;
      end
      r = (sum + 64'd32768) >> 16;
      if (r > 64'd32767) r = 64'd32767;
      tab[k] = r[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_sine();

  function automatic logic [IdxBits-1:0] bit_rev(logic [IdxBits-1:0] x,
                                                 logic [LogBits-1:0] l);
    logic [IdxBits-1:0] r;
    for (int b = 0; b < IdxBits; b++) r[b] = x[IdxBits-1-b];
    return r >> (4'(IdxBits) - l);
  endfunction

  function automatic logic [BinBits-1:0] sat_bin(logic signed [32:0] v);
    if (v > 33'sd134217727) return 28'h7FF_FFFF;
    if (v < -33'sd134217728) return 28'h800_0000;
    return v[BinBits-1:0];
  endfunction

endpackage

/* design/radix2_fft_core.sv */
// radix2_fft_core: frame-based radix-2 DIT FFT with one shared butterfly
// datapath under a small sequencer. Depends on r2fft_pkg.
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: sample_real, sample_imag
// m_axis    out  m_axis_tvalid/tready      tdata: bin_real, bin_imag, bin_index
//                                          tlast: last_bin
// cfg       in   cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// Steps: the last sample of a frame starts the transform: a bit-reversed copy,
// then the butterflies (N/2*log2 N of them, each through the states BRD, BMR,
// BMI, BWA and BWB; the shared multiply unit is used twice per butterfly),
// then scaling for the inverse. No new sample is taken until the transform
// is done.
// Reset clears control only; stores are undefined until written. A stalled
// result holds the output register; the next item is taken once it drains.
// Register writes are taken only while idle, and hold off the sample side.
module radix2_fft_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [15:0] sample_real, [31:16] sample_imag
  input  logic [r2fft_pkg::InBits-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [27:0] bin_real, [55:28] bin_imag, [65:56] bin_index, rest zero
  output logic [r2fft_pkg::OutBits-1:0]  m_axis_tdata,
  output logic                           m_axis_tlast,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [0:0]                     cfg_index_i,
  input  logic [r2fft_pkg::LogBits-1:0]  cfg_data_i
);
  import r2fft_pkg::*;

  // stores
  logic [InBits-1:0]    load_mem [MaxPoints];
  logic [2*BinBits-1:0] xf_mem   [MaxPoints];

  logic [3:0]           state_q, state_d;
  logic [LogBits-1:0]   log2_q;
  logic                 inv_q, inv_run_q;
  logic [IdxBits-1:0]   fill_q, pos_q;
  logic                 prev_q, emit_q, frame_q;
  logic [IdxBits:0]     cnt_q;
  logic [LogBits-1:0]   stg_q;
  logic [IdxBits-2:0]   k_q;
  logic [InBits-1:0]    ld_rd_q;
  logic [2*BinBits-1:0] rda_q, rdb_q;
  logic signed [30:0]   tr_q, ti_q;
  logic [2*BinBits-1:0] wb_q;
  logic                 m_valid_q;
  logic [BinBits-1:0]   out_re_q, out_im_q;
  logic [IdxBits-1:0]   out_idx_q;
  logic                 out_last_q;

  logic [IdxBits-1:0]   nmask;
  logic [IdxBits:0]     npts;
  logic                 in_acc;
  assign nmask  = IdxBits'((11'd1 << log2_q) - 11'd1);
  assign npts   = (IdxBits+1)'(11'd1 << log2_q);
  // a pending register write wins over a sample in the same cycle
  assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready) &&
                         !cfg_valid_i;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = (state_q == ST_IDLE);

  // butterfly addressing: a gets a zero inserted at bit stg, b a one
  logic [IdxBits-1:0] kx, hmask, ba, bb, tw;
  assign kx    = {1'b0, k_q};
  assign hmask = IdxBits'((10'd1 << stg_q) - 10'd1);
  assign ba    = ((kx & ~hmask) << 1) | (kx & hmask);
  assign bb    = ba | IdxBits'(10'd1 << stg_q);
  assign tw    = (kx & hmask) << (4'(MaxLog - 1) - stg_q);

  // twiddle from quarter-wave table
  logic signed [16:0] cw, sw, se;
  always_comb begin
    if (tw <= 10'(Quarter)) begin
      cw = $signed({1'b0, SineTab[9'(10'(Quarter) - tw)]});
      sw = $signed({1'b0, SineTab[tw[8:0]]});
    end else begin
      cw = -$signed({1'b0, SineTab[9'(tw - 10'(Quarter))]});
      sw = $signed({1'b0, SineTab[9'(10'(2*Quarter) - tw)]});
    end
    se = inv_run_q ? -sw : sw;
  end

  // shared multiply-accumulate: a1*b1 + a2*b2 rounded half up to Q0
  logic signed [BinBits-1:0] ur, ui, xr, xi;
  assign ur = $signed(rda_q[BinBits-1:0]);
  assign ui = $signed(rda_q[2*BinBits-1:BinBits]);
  assign xr = $signed(rdb_q[BinBits-1:0]);
  assign xi = $signed(rdb_q[2*BinBits-1:BinBits]);

  logic signed [16:0]        ma1, ma2;
  logic signed [BinBits-1:0] mb1, mb2;
  logic signed [45:0]        macc;
  logic signed [30:0]        mres;
  always_comb begin
    ma1 = cw;
    if (state_q == ST_BMI) begin
      mb1 = xi; ma2 = -se; mb2 = xr;
    end else begin
      mb1 = xr; ma2 = se;  mb2 = xi;
    end
    macc = 46'(ma1 * mb1) + 46'(ma2 * mb2) + 46'sd16384;
    mres = macc[45:15];
  end

  // butterfly sums
  logic [BinBits-1:0] sa_re, sa_im, sb_re, sb_im;
  assign sa_re = sat_bin(33'(ur) + 33'(tr_q));
  assign sa_im = sat_bin(33'(ui) + 33'(ti_q));
  assign sb_re = sat_bin(33'(ur) - 33'(tr_q));
  assign sb_im = sat_bin(33'(ui) - 33'(ti_q));

  // store ports
  logic [IdxBits-1:0]   rd_a_addr, cpy_prev;
  logic                 xf_we;
  logic [IdxBits-1:0]   xf_wa;
  logic [2*BinBits-1:0] xf_wd;
  logic signed [BinBits-1:0] ld_re, ld_im, sc_re, sc_im;
  assign cpy_prev = IdxBits'(cnt_q - 11'd1);
  assign ld_re = BinBits'($signed(ld_rd_q[SampBits-1:0]));
  assign ld_im = BinBits'($signed(ld_rd_q[InBits-1:SampBits]));
  assign sc_re = ur >>> log2_q;
  assign sc_im = ui >>> log2_q;

  always_comb begin
    rd_a_addr = ba;
    xf_we = 1'b0;
    xf_wa = ba;
    xf_wd = {sa_im, sa_re};
    case (state_q)
      ST_IDLE: rd_a_addr = fill_q;
      ST_SCL: begin
        rd_a_addr = cnt_q[IdxBits-1:0];
        xf_we = (cnt_q != '0);
        xf_wa = cpy_prev;
        xf_wd = {sc_im, sc_re};
      end
      ST_CPY: begin
        xf_we = (cnt_q != '0);
        xf_wa = bit_rev(cpy_prev, log2_q);
        xf_wd = {ld_im, ld_re};
      end
      ST_BWA: xf_we = 1'b1;
      ST_BWB: begin
        xf_we = 1'b1;
        xf_wa = bb;
        xf_wd = wb_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) load_mem[fill_q] <= s_axis_tdata;
    ld_rd_q <= load_mem[cnt_q[IdxBits-1:0]];
    if (xf_we) xf_mem[xf_wa] <= xf_wd;
    rda_q <= xf_mem[rd_a_addr];
    rdb_q <= xf_mem[bb];
    if (state_q == ST_BMR) tr_q <= mres;
    if (state_q == ST_BMI) ti_q <= mres;
    if (state_q == ST_BWA) wb_q <= {sb_im, sb_re};
    if (state_q == ST_OUTW && emit_q) begin
      out_re_q   <= rda_q[BinBits-1:0];
      out_im_q   <= rda_q[2*BinBits-1:BinBits];
      out_idx_q  <= pos_q;
      out_last_q <= (pos_q == nmask);
    end
    if (in_acc) pos_q <= fill_q;
  end

  // sequencer
  logic last_k, last_stg;
  assign last_k   = ({1'b0, k_q} == IdxBits'(nmask >> 1));
  assign last_stg = (stg_q == log2_q - 4'd1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_OUTW;
      ST_OUTW: state_d = frame_q ? ST_CPY : ST_IDLE;
      ST_CPY:  if (cnt_q == npts)
                 state_d = (log2_q == '0) ? ST_IDLE : ST_BRD;
      ST_BRD:  state_d = ST_BMR;
      ST_BMR:  state_d = ST_BMI;
      ST_BMI:  state_d = ST_BWA;
      ST_BWA:  state_d = ST_BWB;
      ST_BWB:  if (last_k && last_stg) state_d = inv_run_q ? ST_SCL : ST_IDLE;
               else state_d = ST_BRD;
      ST_SCL:  if (cnt_q == npts) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      log2_q    <= LogBits'(MaxLog);
      inv_q     <= 1'b0;
      inv_run_q <= 1'b0;
      fill_q    <= '0;
      prev_q    <= 1'b0;
      emit_q    <= 1'b0;
      frame_q   <= 1'b0;
      cnt_q     <= '0;
      stg_q     <= '0;
      k_q       <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgLog2Size) begin
          log2_q <= (cfg_data_i > LogBits'(MaxLog)) ? LogBits'(MaxLog) : cfg_data_i;
          fill_q <= '0;
          prev_q <= 1'b0;
        end else begin
          inv_q <= cfg_data_i[0];
        end
      end
      case (state_q)
        ST_IDLE: if (in_acc) begin
          emit_q  <= prev_q;
          frame_q <= (fill_q == nmask);
          fill_q  <= (fill_q == nmask) ? '0 : fill_q + 10'd1;
        end
        ST_OUTW: begin
          if (emit_q) m_valid_q <= 1'b1;
          cnt_q     <= '0;
          stg_q     <= '0;
          k_q       <= '0;
          inv_run_q <= inv_q;
        end
        ST_CPY: begin
          cnt_q <= cnt_q + 11'd1;
          if (cnt_q == npts) begin
            cnt_q <= '0;
            if (log2_q == '0) prev_q <= 1'b1;
          end
        end
        ST_BWB: begin
          if (last_k) begin
            k_q   <= '0;
            stg_q <= stg_q + 4'd1;
            if (last_stg && !inv_run_q) prev_q <= 1'b1;
          end else begin
            k_q <= k_q + 9'd1;
          end
        end
        ST_SCL: begin
          cnt_q <= cnt_q + 11'd1;
          if (cnt_q == npts) prev_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OutBits'({out_idx_q, out_im_q, out_re_q});
  assign m_axis_tlast  = out_last_q;

endmodule
